// ===== rtl/rpe_pkg.sv =====
package rpe_pkg;

    localparam int DATA_WIDTH     = 16;
    localparam int COEF_WIDTH     = 16;
    localparam int COEF_FRAC_BITS = 14;
    localparam int INDEX_WIDTH    = 7;
    localparam int HD_REG_W       = 8;
    localparam int SEQ_REG_W      = 13;
    localparam int HD_W           = 10;
    localparam int SL_W           = 17;
    localparam int PROD_W         = DATA_WIDTH + COEF_WIDTH;
    localparam int SUM_W          = PROD_W + 2;
    localparam int Q_W            = SUM_W - COEF_FRAC_BITS;
    localparam int CFG_ADDR_W     = 4;
    localparam int CFG_DATA_W     = 32;

    localparam logic [1:0] REG_HEAD_DIM    = 2'd0;
    localparam logic [1:0] REG_SEQ_LEN     = 2'd1;
    localparam logic [1:0] REG_ROTATED_LEN = 2'd2;
    localparam logic [1:0] REG_INTERLEAVED = 2'd3;

    localparam logic [HD_REG_W-1:0]  HEAD_DIM_RST    = 8'd64;
    localparam logic [SEQ_REG_W-1:0] SEQ_LEN_RST     = 13'd256;
    localparam logic [SEQ_REG_W-1:0] ROTATED_LEN_RST = 13'd256;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [Q_W-1:0]   Q_MAX      = Q_W'((1 << (DATA_WIDTH - 1)) - 1);
    localparam logic signed [Q_W-1:0]   Q_MIN      = ~Q_MAX;

    typedef struct packed {
        logic [HD_W-1:0] hd;
        logic [HD_W-1:0] half;
        logic [SL_W-1:0] sl;
        logic [SL_W-1:0] prefix;
        logic            interleaved;
    } t_cfg;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] x;
        logic [COEF_WIDTH-1:0] sin;
        logic [COEF_WIDTH-1:0] cos;
    } t_front;

    typedef struct packed {
        logic                   pass;
        logic [INDEX_WIDTH-1:0] idx;
        logic [INDEX_WIDTH-1:0] fidx;
        logic                   done;
    } t_item;

    typedef struct packed {
        logic                  sat;
        logic [DATA_WIDTH-1:0] value;
    } t_res;

    function automatic t_res round_sat(input logic signed [SUM_W-1:0] sum);
        logic signed [SUM_W-1:0] v;
        logic signed [Q_W-1:0]   q;
        t_res                    r;
        v = sum + ROUND_HALF;
        q = v[SUM_W-1:COEF_FRAC_BITS];
        if (q > Q_MAX) begin
            r.sat   = 1'b1;
            r.value = Q_MAX[DATA_WIDTH-1:0];
        end else if (q < Q_MIN) begin
            r.sat   = 1'b1;
            r.value = Q_MIN[DATA_WIDTH-1:0];
        end else begin
            r.sat   = 1'b0;
            r.value = q[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/rpe_cfg.sv =====
module rpe_cfg #(
    parameter int MAX_HEAD_DIM = 128,
    parameter int MAX_SEQ_LEN  = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rpe_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [rpe_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [rpe_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready,
    output rpe_pkg::t_cfg                     o_cfg
);
    import rpe_pkg::*;

    localparam logic [HD_W-1:0] HD_MAX = HD_W'(MAX_HEAD_DIM);
    localparam logic [SL_W-1:0] SL_MAX = SL_W'(MAX_SEQ_LEN);

    logic [HD_REG_W-1:0]  r_head_dim;
    logic [SEQ_REG_W-1:0] r_seq_len;
    logic [SEQ_REG_W-1:0] r_rotated_len;
    logic                 r_interleaved;

    logic [1:0]      reg_sel;
    logic            wr_en;
    logic [HD_W-1:0] hd_raw;
    logic [HD_W-1:0] hd_clip;
    logic [HD_W-1:0] hd_even;
    logic [HD_W-1:0] hd_eff;
    logic [SL_W-1:0] sl_raw;
    logic [SL_W-1:0] sl_min;
    logic [SL_W-1:0] sl_eff;
    logic [SL_W-1:0] rot_len;

    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_dim    <= HEAD_DIM_RST;
            r_seq_len     <= SEQ_LEN_RST;
            r_rotated_len <= ROTATED_LEN_RST;
            r_interleaved <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_HEAD_DIM:    r_head_dim    <= pwdata[HD_REG_W-1:0];
                REG_SEQ_LEN:     r_seq_len     <= pwdata[SEQ_REG_W-1:0];
                REG_ROTATED_LEN: r_rotated_len <= pwdata[SEQ_REG_W-1:0];
                REG_INTERLEAVED: r_interleaved <= pwdata[0];
                default:         r_interleaved <= r_interleaved;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_HEAD_DIM:    prdata = CFG_DATA_W'(r_head_dim);
            REG_SEQ_LEN:     prdata = CFG_DATA_W'(r_seq_len);
            REG_ROTATED_LEN: prdata = CFG_DATA_W'(r_rotated_len);
            REG_INTERLEAVED: prdata = CFG_DATA_W'(r_interleaved);
            default:         prdata = '0;
        endcase
    end

    // Out-of-range settings are folded into legal ones here.
    assign hd_raw  = HD_W'(r_head_dim);
    assign hd_clip = (hd_raw > HD_MAX) ? HD_MAX : hd_raw;
    assign hd_even = {hd_clip[HD_W-1:1], 1'b0};
    assign hd_eff  = (hd_even < HD_W'(2)) ? HD_W'(2) : hd_even;

    assign sl_raw  = SL_W'(r_seq_len);
    assign sl_min  = (sl_raw == '0) ? SL_W'(1) : sl_raw;
    assign sl_eff  = (sl_min > SL_MAX) ? SL_MAX : sl_min;
    assign rot_len = SL_W'(r_rotated_len);

    assign o_cfg.hd          = hd_eff;
    assign o_cfg.half        = hd_eff >> 1;
    assign o_cfg.sl          = sl_eff;
    assign o_cfg.prefix      = (rot_len >= sl_eff) ? '0 : sl_eff - rot_len;
    assign o_cfg.interleaved = r_interleaved;

endmodule

// ===== rtl/rpe_seq.sv =====
module rpe_seq #(
    parameter int MAX_HEAD_DIM = 128,
    parameter int MAX_SEQ_LEN  = 4096,
    localparam int HALF_DEPTH  = MAX_HEAD_DIM / 2,
    localparam int ADDR_W      = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rpe_pkg::t_cfg      i_cfg,
    input  logic               i_accept,
    output rpe_pkg::t_item     o_item,
    output logic               o_emit,
    output logic               o_wr_en,
    output logic               o_rd_en,
    output logic [ADDR_W-1:0]  o_addr
);
    import rpe_pkg::*;

    localparam int EC_W  = $clog2(MAX_HEAD_DIM);
    localparam int ROW_W = (MAX_SEQ_LEN > 1) ? $clog2(MAX_SEQ_LEN) : 1;

    logic [EC_W-1:0]  r_ec;
    logic [ROW_W-1:0] r_row;
    logic [EC_W-1:0]  n_ec;
    logic [ROW_W-1:0] n_row;

    logic [EC_W-1:0]  idx;
    logic [ROW_W-1:0] row;
    logic [HD_W-1:0]  idx_w;
    logic [HD_W-1:0]  idx_inc;
    logic [SL_W-1:0]  row_inc;
    logic [HD_W-1:0]  slot_w;
    logic [HD_W-1:0]  fidx_w;
    logic             pass;
    logic             second;

    // A counter left beyond a newly written bound restarts at zero.
    assign idx     = (HD_W'(r_ec) >= i_cfg.hd) ? '0 : r_ec;
    assign row     = (SL_W'(r_row) >= i_cfg.sl) ? '0 : r_row;
    assign idx_w   = HD_W'(idx);
    assign idx_inc = idx_w + HD_W'(1);
    assign row_inc = SL_W'(row) + SL_W'(1);

    assign pass   = SL_W'(row) < i_cfg.prefix;
    assign second = i_cfg.interleaved ? idx[0] : (idx_w >= i_cfg.half);
    assign slot_w = i_cfg.interleaved ? '0 : (second ? idx_w - i_cfg.half : idx_w);
    assign fidx_w = i_cfg.interleaved ? idx_w - HD_W'(1) : idx_w - i_cfg.half;

    assign o_addr = (slot_w >= HD_W'(HALF_DEPTH)) ? '0 : slot_w[ADDR_W-1:0];

    assign o_item.pass = pass;
    assign o_item.idx  = idx_w[INDEX_WIDTH-1:0];
    assign o_item.fidx = fidx_w[INDEX_WIDTH-1:0];
    assign o_item.done = (idx_inc == i_cfg.hd);

    assign o_emit  = pass || second;
    assign o_wr_en = i_accept && !pass && !second;
    assign o_rd_en = i_accept && !pass && second;

    always_comb begin
        n_ec  = r_ec;
        n_row = r_row;
        if (i_accept) begin
            if (idx_inc >= i_cfg.hd) begin
                n_ec  = '0;
                n_row = (row_inc >= i_cfg.sl) ? '0 : row_inc[ROW_W-1:0];
            end else begin
                n_ec  = idx_inc[EC_W-1:0];
                n_row = row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ec  <= '0;
            r_row <= '0;
        end else begin
            r_ec  <= n_ec;
            r_row <= n_row;
        end
    end

endmodule

// ===== rtl/rpe_buf.sv =====
module rpe_buf #(
    parameter int MAX_HEAD_DIM = 128,
    localparam int HALF_DEPTH  = MAX_HEAD_DIM / 2,
    localparam int ADDR_W      = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic               i_rd_en,
    input  logic [ADDR_W-1:0]  i_addr,
    input  rpe_pkg::t_front    i_wdata,
    output rpe_pkg::t_front    o_rdata
);
    import rpe_pkg::*;

    t_front mem [HALF_DEPTH];
    t_front r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_rd_en) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rpe_rot.sv =====
module rpe_rot (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_load,
    input  rpe_pkg::t_item                        i_item,
    input  rpe_pkg::t_front                       i_cur,
    input  rpe_pkg::t_front                       i_front,
    output logic                                  o_ready,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [rpe_pkg::DATA_WIDTH-1:0]        o_out_value,
    output logic [rpe_pkg::INDEX_WIDTH-1:0]       o_out_index,
    output logic                                  o_row_done,
    output logic                                  o_saturated,
    output logic                                  o_last
);
    import rpe_pkg::*;

    typedef struct packed {
        logic [DATA_WIDTH-1:0]  value;
        logic [INDEX_WIDTH-1:0] idx;
        logic                   done;
        logic                   sat;
        logic                   last;
    } t_out;

    logic   r_s1_valid;
    t_item  r_s1_item;
    t_front r_s1_cur;

    logic                     r_s2_valid;
    t_item                    r_s2_item;
    logic [DATA_WIDTH-1:0]    r_s2_x;
    logic signed [PROD_W-1:0] r_p_fc;
    logic signed [PROD_W-1:0] r_p_bs;
    logic signed [PROD_W-1:0] r_p_bc;
    logic signed [PROD_W-1:0] r_p_fs;

    logic [1:0] r_cnt;
    t_out       r_out [2];

    logic                    xfer;
    logic                    can_load;
    logic                    s2_ready;
    logic                    s1_ready;
    logic                    out_load;
    logic signed [SUM_W-1:0] sum_f;
    logic signed [SUM_W-1:0] sum_b;
    t_res                    res_f;
    t_res                    res_b;
    t_out                    ent0;
    t_out                    ent1;

    assign xfer     = (r_cnt != 2'd0) && !i_stall;
    assign can_load = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && xfer);
    assign s2_ready = !r_s2_valid || can_load;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign out_load = r_s2_valid && can_load;
    assign o_ready  = s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_load;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_load) begin
            r_s1_item <= i_item;
            r_s1_cur  <= i_cur;
        end
        if (s2_ready && r_s1_valid) begin
            r_s2_item <= r_s1_item;
            r_s2_x    <= r_s1_cur.x;
            r_p_fc    <= $signed(i_front.x) * $signed(i_front.cos);
            r_p_bs    <= $signed(r_s1_cur.x) * $signed(i_front.sin);
            r_p_bc    <= $signed(r_s1_cur.x) * $signed(r_s1_cur.cos);
            r_p_fs    <= $signed(i_front.x) * $signed(r_s1_cur.sin);
        end
    end

    assign sum_f = SUM_W'(r_p_fc) - SUM_W'(r_p_bs);
    assign sum_b = SUM_W'(r_p_bc) + SUM_W'(r_p_fs);
    assign res_f = round_sat(sum_f);
    assign res_b = round_sat(sum_b);

    always_comb begin
        if (r_s2_item.pass) begin
            ent0 = '{value: r_s2_x, idx: r_s2_item.idx, done: r_s2_item.done,
                     sat: 1'b0, last: 1'b1};
        end else begin
            ent0 = '{value: res_f.value, idx: r_s2_item.fidx, done: 1'b0,
                     sat: res_f.sat, last: 1'b0};
        end
        ent1 = '{value: res_b.value, idx: r_s2_item.idx, done: r_s2_item.done,
                 sat: res_b.sat, last: 1'b1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (out_load) begin
            r_cnt <= r_s2_item.pass ? 2'd1 : 2'd2;
        end else if (xfer) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out[0] <= ent0;
            r_out[1] <= ent1;
        end else if (xfer) begin
            r_out[0] <= r_out[1];
        end
    end

    assign o_valid     = (r_cnt != 2'd0);
    assign o_out_value = r_out[0].value;
    assign o_out_index = r_out[0].idx;
    assign o_row_done  = r_out[0].done;
    assign o_saturated = r_out[0].sat;
    assign o_last      = r_out[0].last;

endmodule

// ===== rtl/rotary_position_embedding_core.sv =====
// Rotary position embedding for a stream of row elements.
// Input channel: one transfer per element (i_x_value, i_sin_value, i_cos_value),
// in row order. The block counts the element index and the row position.
// Rows before seq_len - rotated_len pass through, one result each. In rotated
// rows the first element of each pair is stored in the front buffer and gives
// no result; the second element gives two results, the partner's and its own.
// Output channel: one result per transfer, tagged with its element index.
// An input transfer reaches its first result through the stage-one, stage-two
// and output registers. Pass-through rows and interleaved rotation sustain one
// element per cycle while the receiver does not stall. In half mode each
// back-half element gives two results to the single output port, which delivers
// one result per cycle, so the input stalls while those results drain.
// While the receiver stalls, results wait in the output register and the input
// stall rises once the pipeline behind it is full.
// Reset clears the counters and loads the register defaults; the front buffer
// needs no clearing pass. The user must write registers through the APB-style
// port only while the block is idle; the block itself does not enforce this.
module rotary_position_embedding_core #(
    parameter int MAX_HEAD_DIM = 128,
    parameter int MAX_SEQ_LEN  = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [rpe_pkg::CFG_ADDR_W-1:0]        paddr,
    input  logic [rpe_pkg::CFG_DATA_W-1:0]        pwdata,
    output logic [rpe_pkg::CFG_DATA_W-1:0]        prdata,
    output logic                                  pready,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [rpe_pkg::DATA_WIDTH-1:0] i_x_value,
    input  logic signed [rpe_pkg::COEF_WIDTH-1:0] i_sin_value,
    input  logic signed [rpe_pkg::COEF_WIDTH-1:0] i_cos_value,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [rpe_pkg::DATA_WIDTH-1:0] o_out_value,
    output logic [rpe_pkg::INDEX_WIDTH-1:0]       o_out_index,
    output logic                                  o_row_done,
    output logic                                  o_saturated,
    output logic                                  o_last
);
    import rpe_pkg::*;

    localparam int HALF_DEPTH = MAX_HEAD_DIM / 2;
    localparam int ADDR_W     = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;

    t_cfg              cfg;
    t_item             item;
    t_front            cur;
    t_front            front;
    logic              emit;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic              rot_ready;
    logic              accept;
    logic [DATA_WIDTH-1:0] out_value;

    assign o_stall   = !rot_ready;
    assign accept    = i_valid && rot_ready;
    assign cur.x     = i_x_value;
    assign cur.sin   = i_sin_value;
    assign cur.cos   = i_cos_value;
    assign o_out_value = out_value;

    rpe_cfg #(
        .MAX_HEAD_DIM (MAX_HEAD_DIM),
        .MAX_SEQ_LEN  (MAX_SEQ_LEN)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rpe_seq #(
        .MAX_HEAD_DIM (MAX_HEAD_DIM),
        .MAX_SEQ_LEN  (MAX_SEQ_LEN)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (accept),
        .o_item   (item),
        .o_emit   (emit),
        .o_wr_en  (wr_en),
        .o_rd_en  (rd_en),
        .o_addr   (addr)
    );

    rpe_buf #(
        .MAX_HEAD_DIM (MAX_HEAD_DIM)
    ) u_buf (
        .i_clk   (i_clk),
        .i_wr_en (wr_en),
        .i_rd_en (rd_en),
        .i_addr  (addr),
        .i_wdata (cur),
        .o_rdata (front)
    );

    rpe_rot u_rot (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept && emit),
        .i_item      (item),
        .i_cur       (cur),
        .i_front     (front),
        .o_ready     (rot_ready),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_value (out_value),
        .o_out_index (o_out_index),
        .o_row_done  (o_row_done),
        .o_saturated (o_saturated),
        .o_last      (o_last)
    );

endmodule
